/* src/tcc_pkg.sv */
`timescale 1ns / 1ps
package tcc_pkg;

  localparam int MEM_BYTES_DEF = 32768;
  localparam int DATA_W        = 16;
  localparam int PC_W          = 15;
  localparam int WORD_W        = 32;
  localparam int NUM_REGS      = 8;
  localparam int RID_W         = 3;

  localparam logic [7:0] OP_STOP = 8'd0;
  localparam logic [7:0] OP_MOVE = 8'd1;
  localparam logic [7:0] OP_ADD  = 8'd2;
  localparam logic [7:0] OP_SUB  = 8'd3;
  localparam logic [7:0] OP_MUL  = 8'd4;
  localparam logic [7:0] OP_DIV  = 8'd5;
  localparam logic [7:0] OP_AND  = 8'd6;
  localparam logic [7:0] OP_OR   = 8'd7;
  localparam logic [7:0] OP_NOT  = 8'd8;
  localparam logic [7:0] OP_CMP  = 8'd9;
  localparam logic [7:0] OP_JMP  = 8'd10;
  localparam logic [7:0] OP_IN   = 8'd11;
  localparam logic [7:0] OP_OUT  = 8'd12;

  localparam logic [3:0] JC_ALWAYS = 4'd0;
  localparam logic [3:0] JC_EQ     = 4'd1;
  localparam logic [3:0] JC_GT     = 4'd2;
  localparam logic [3:0] JC_LT     = 4'd3;

  localparam logic [DATA_W-1:0] FLAG_EQ = 16'h0000;
  localparam logic [DATA_W-1:0] FLAG_GT = 16'h0001;
  localparam logic [DATA_W-1:0] FLAG_LT = 16'hFFFF;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

endpackage

/* src/tcc_if.sv */
`timescale 1ns / 1ps
interface tcc_in_if import tcc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              command;
  logic [PC_W-1:0]   address;
  logic [WORD_W-1:0] load_word;
  logic [DATA_W-1:0] in_value;

  modport source(output valid, command, address, load_word, in_value, input ready);
  modport sink(input valid, command, address, load_word, in_value, output ready);
endinterface

interface tcc_out_if import tcc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PC_W-1:0]   pc;
  logic              out_valid;
  logic [DATA_W-1:0] out_value;
  logic              halted;
  logic              fault;

  modport source(output valid, pc, out_valid, out_value, halted, fault, input ready);
  modport sink(input valid, pc, out_valid, out_value, halted, fault, output ready);
endinterface

/* src/tcc_ram.sv */
`timescale 1ns / 1ps
module tcc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/tcc_div.sv */
`timescale 1ns / 1ps
module tcc_div import tcc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DATA_W-1:0] dividend,
  input  logic [DATA_W-1:0] divisor,
  output logic              done,
  output logic [DATA_W-1:0] quotient
);

  localparam int CW = $clog2(DATA_W);

  logic              busy_r;
  logic              done_r;
  logic [CW-1:0]     cnt_r;
  logic [DATA_W-1:0] rem_r;
  logic [DATA_W-1:0] q_r;
  logic [DATA_W-1:0] dvs_r;
  logic              neg_r;
  logic [DATA_W:0]   shifted;
  logic [DATA_W:0]   diff;

  // Restoring division on magnitudes, one quotient bit per cycle.
  assign shifted = {rem_r, q_r[DATA_W-1]};
  assign diff    = shifted - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        q_r    <= dividend[DATA_W-1] ? -dividend : dividend;
        dvs_r  <= divisor[DATA_W-1] ? -divisor : divisor;
        neg_r  <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
      end else if (busy_r) begin
        if (!diff[DATA_W]) begin
          rem_r <= diff[DATA_W-1:0];
          q_r   <= {q_r[DATA_W-2:0], 1'b1};
        end else begin
          rem_r <= shifted[DATA_W-1:0];
          q_r   <= {q_r[DATA_W-2:0], 1'b0};
        end
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(DATA_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? -q_r : q_r;

endmodule

/* src/toy_cpu_16bit_core.sv */
`timescale 1ns / 1ps
// 16-bit toy processor with one shared halfword memory.
// Input channel in_ch carries one transaction per command: a load writes a
// 32-bit program word (low halfword at the lower address, word aligned), a step
// fetches the instruction at the program counter and executes it unless the core has stopped.
// Output channel out_ch returns exactly one result transaction per input:
// the program counter afterwards, an output value with its flag, the halted
// flag and a fault flag.
// A divide waits for the bit-serial divider. Program and data share one
// single-read-port memory, so the two fetch reads and the operand read go
// one after another, as do the two register file reads.
// One transaction is worked on at a time; the next is accepted as soon as its
// result sits in the output register, even while the receiver stalls it.
// After reset the memory is swept to zero, one halfword a cycle, over the whole
// memory; in_ch.ready stays low until the sweep ends.
// MEM_BYTES must be a power of two.
module toy_cpu_16bit_core import tcc_pkg::*; #(
  parameter int MEM_BYTES = MEM_BYTES_DEF
) (
  input logic      clk,
  input logic      rst_n,
  tcc_in_if.sink   in_ch,
  tcc_out_if.source out_ch
);

  localparam int MEM_DEPTH = MEM_BYTES / 2;
  localparam int MAW       = $clog2(MEM_DEPTH);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_LD0, S_LD1, S_F0, S_F1, S_F2,
    S_RA, S_RB, S_RC, S_MR, S_MC, S_EX, S_DV, S_DONE
  } state_t;

  typedef struct packed {
    logic              rf_we;
    logic              mem_we;
    logic              flag_we;
    logic [DATA_W-1:0] wd;
    logic              fault;
    logic              ov;
    logic [DATA_W-1:0] oval;
    logic              stop;
    logic              jump;
    logic              div_go;
  } exec_t;

  function automatic logic [MAW-1:0] idx16(input logic [DATA_W-1:0] v);
    return v[MAW:1];
  endfunction

  state_t            state_r;
  logic [MAW-1:0]    clr_cnt_r;
  logic [PC_W-1:0]   pc_r;
  logic [DATA_W-1:0] flag_r;
  logic              stop_r;
  logic [NUM_REGS-1:0] rfv_r;
  logic              rfq_v_r;
  logic [PC_W-1:0]   addr_r;
  logic [WORD_W-1:0] word_r;
  logic [DATA_W-1:0] inv_r;
  logic [DATA_W-1:0] lo_r;
  logic [WORD_W-1:0] ir_r;
  logic [DATA_W-1:0] a_r;
  logic [DATA_W-1:0] b_r;
  logic [DATA_W-1:0] m_r;
  logic              r_ov_r;
  logic [DATA_W-1:0] r_val_r;
  logic              r_fault_r;
  logic              o_vld_r;
  logic [PC_W-1:0]   o_pc_r;
  logic              o_ov_r;
  logic [DATA_W-1:0] o_val_r;
  logic              o_halt_r;
  logic              o_fault_r;

  logic              mem_we;
  logic [MAW-1:0]    mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic [MAW-1:0]    mem_raddr;
  logic [DATA_W-1:0] mem_rdata;
  logic              rf_we;
  logic [RID_W-1:0]  rf_waddr;
  logic [DATA_W-1:0] rf_wdata;
  logic [RID_W-1:0]  rf_raddr;
  logic [DATA_W-1:0] rf_rdata;
  logic              div_start;
  logic              div_done;
  logic [DATA_W-1:0] div_q;

  logic [7:0]        op;
  logic [3:0]        tgt;
  logic [3:0]        src;
  logic [DATA_W-1:0] imm;
  logic              tgt_ok;
  logic              tgt_ar;
  logic              src_ok;
  logic              src_ar;
  logic              is_alu;
  logic [DATA_W-1:0] ma_val;
  logic [DATA_W-1:0] bop;
  logic [DATA_W-1:0] rf_rd;
  logic [MAW-1:0]    ld_base;
  exec_t             ex;

  assign op     = ir_r[31:24];
  assign tgt    = ir_r[23:20];
  assign src    = ir_r[19:16];
  assign imm    = ir_r[15:0];
  assign tgt_ok = (tgt >= 4'd1) && (tgt <= 4'd8);
  assign tgt_ar = (tgt >= 4'd5) && (tgt <= 4'd8);
  assign src_ok = (src >= 4'd1) && (src <= 4'd8);
  assign src_ar = (src >= 4'd5) && (src <= 4'd8);
  assign is_alu = (op >= OP_ADD) && (op <= OP_CMP);
  assign rf_rd  = rfq_v_r ? rf_rdata : '0;
  assign ld_base = idx16({1'b0, addr_r[PC_W-1:2], 2'b00});

  // Loads through a source address register read via the source; everything
  // else that touches memory goes through the target register.
  assign ma_val = (src_ar && (op == OP_MOVE || is_alu)) ? b_r : a_r;
  assign bop    = (src == 4'd0) ? imm : ((src < 4'd5) ? b_r : m_r);

  tcc_ram #(.WIDTH(DATA_W), .DEPTH(MEM_DEPTH)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  tcc_ram #(.WIDTH(DATA_W), .DEPTH(NUM_REGS)) u_rf (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (rf_wdata),
    .raddr (rf_raddr),
    .rdata (rf_rdata)
  );

  tcc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (a_r),
    .divisor  (bop),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    ex      = '0;
    ex.wd   = '0;
    case (op)
      OP_STOP: ex.stop = 1'b1;
      OP_MOVE: begin
        if (!tgt_ok && (src == 4'd0 || src_ar)) begin
          ex.fault = 1'b1;
        end else if (src == 4'd0) begin
          ex.rf_we = 1'b1;
          ex.wd    = imm;
        end else if (src_ar) begin
          ex.rf_we = 1'b1;
          ex.wd    = m_r;
        end else if (tgt_ar && src_ok) begin
          ex.mem_we = 1'b1;
          ex.wd     = b_r;
        end else begin
          ex.fault = 1'b1;
        end
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_AND, OP_OR, OP_NOT, OP_CMP: begin
        if (!tgt_ok || src > 4'd8) begin
          ex.fault = 1'b1;
        end else begin
          case (op)
            OP_ADD: begin ex.rf_we = 1'b1; ex.wd = a_r + bop; end
            OP_SUB: begin ex.rf_we = 1'b1; ex.wd = a_r - bop; end
            OP_MUL: begin ex.rf_we = 1'b1; ex.wd = DATA_W'(a_r * bop); end
            OP_DIV: begin
              if (bop == '0) begin
                ex.fault = 1'b1;
                ex.rf_we = 1'b1;
              end else begin
                ex.div_go = 1'b1;
              end
            end
            OP_AND: begin
              ex.rf_we = 1'b1;
              ex.wd    = DATA_W'((a_r != '0) && (bop != '0));
            end
            OP_OR: begin
              ex.rf_we = 1'b1;
              ex.wd    = DATA_W'((a_r != '0) || (bop != '0));
            end
            OP_NOT: begin
              ex.rf_we = 1'b1;
              ex.wd    = DATA_W'(a_r == '0);
            end
            default: begin
              ex.flag_we = 1'b1;
              if (a_r == bop) begin
                ex.wd = FLAG_EQ;
              end else if ($signed(a_r) > $signed(bop)) begin
                ex.wd = FLAG_GT;
              end else begin
                ex.wd = FLAG_LT;
              end
            end
          endcase
        end
      end
      OP_JMP: begin
        case (src)
          JC_ALWAYS: ex.jump = 1'b1;
          JC_EQ:     ex.jump = (flag_r == FLAG_EQ);
          JC_GT:     ex.jump = (flag_r == FLAG_GT);
          JC_LT:     ex.jump = (flag_r == FLAG_LT);
          default:   ex.fault = 1'b1;
        endcase
      end
      OP_IN: begin
        if (!tgt_ok) begin
          ex.fault = 1'b1;
        end else if (tgt_ar) begin
          ex.mem_we = 1'b1;
          ex.wd     = inv_r;
        end else begin
          ex.rf_we = 1'b1;
          ex.wd    = inv_r;
        end
      end
      OP_OUT: begin
        if (!tgt_ok) begin
          ex.fault = 1'b1;
        end else begin
          ex.ov   = 1'b1;
          ex.oval = tgt_ar ? m_r : a_r;
        end
      end
      default: ;
    endcase
  end

  // Memory and register file port control, and the divider start.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx16(a_r);
    mem_wdata = ex.wd;
    mem_raddr = idx16({1'b0, pc_r});
    rf_we     = 1'b0;
    rf_waddr  = tgt[RID_W-1:0] - RID_W'(1);
    rf_wdata  = ex.wd;
    rf_raddr  = tgt[RID_W-1:0] - RID_W'(1);
    div_start = 1'b0;
    case (state_r)
      S_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_r;
        mem_wdata = '0;
      end
      S_LD0: begin
        mem_we    = 1'b1;
        mem_waddr = ld_base;
        mem_wdata = word_r[DATA_W-1:0];
      end
      S_LD1: begin
        mem_we    = 1'b1;
        mem_waddr = ld_base | MAW'(1);
        mem_wdata = word_r[WORD_W-1:DATA_W];
      end
      S_F1: mem_raddr = idx16({1'b0, pc_r}) + MAW'(1);
      S_RB: rf_raddr = src[RID_W-1:0] - RID_W'(1);
      S_MR: mem_raddr = idx16(ma_val);
      S_EX: begin
        mem_we    = ex.mem_we;
        rf_we     = ex.rf_we;
        div_start = ex.div_go;
      end
      S_DV: begin
        rf_we    = div_done;
        rf_wdata = div_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLR;
      clr_cnt_r <= '0;
      pc_r      <= '0;
      flag_r    <= '0;
      stop_r    <= 1'b0;
      rfv_r     <= '0;
      o_vld_r   <= 1'b0;
    end else begin
      // In S_DONE the output register is reloaded below instead.
      if (out_ch.valid && out_ch.ready && state_r != S_DONE) begin
        o_vld_r <= 1'b0;
      end
      if (rf_we) begin
        rfv_r[rf_waddr] <= 1'b1;
      end
      case (state_r)
        S_CLR: begin
          clr_cnt_r <= clr_cnt_r + MAW'(1);
          if (clr_cnt_r == '1) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_ch.valid) begin
            addr_r    <= in_ch.address;
            word_r    <= in_ch.load_word;
            inv_r     <= in_ch.in_value;
            r_ov_r    <= 1'b0;
            r_val_r   <= '0;
            r_fault_r <= 1'b0;
            if (in_ch.command == CMD_LOAD) begin
              state_r <= S_LD0;
            end else if (stop_r) begin
              state_r <= S_DONE;
            end else begin
              state_r <= S_F0;
            end
          end
        end
        S_LD0: state_r <= S_LD1;
        S_LD1: state_r <= S_DONE;
        S_F0:  state_r <= S_F1;
        S_F1: begin
          lo_r    <= mem_rdata;
          state_r <= S_F2;
        end
        S_F2: begin
          ir_r    <= {mem_rdata, lo_r};
          state_r <= S_RA;
        end
        S_RA: begin
          rfq_v_r <= rfv_r[rf_raddr];
          state_r <= S_RB;
        end
        S_RB: begin
          a_r     <= rf_rd;
          rfq_v_r <= rfv_r[rf_raddr];
          state_r <= S_RC;
        end
        S_RC: begin
          b_r     <= rf_rd;
          state_r <= S_MR;
        end
        S_MR: state_r <= S_MC;
        S_MC: begin
          m_r     <= mem_rdata;
          state_r <= S_EX;
        end
        S_EX: begin
          r_ov_r    <= ex.ov;
          r_val_r   <= ex.oval;
          r_fault_r <= ex.fault;
          if (ex.flag_we) begin
            flag_r <= ex.wd;
          end
          if (ex.stop) begin
            stop_r <= 1'b1;
          end
          if (ex.div_go) begin
            state_r <= S_DV;
          end else begin
            pc_r    <= ex.jump ? pc_r + imm[PC_W-1:0] : pc_r + PC_W'(4);
            state_r <= S_DONE;
          end
        end
        S_DV: begin
          if (div_done) begin
            pc_r    <= pc_r + PC_W'(4);
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!o_vld_r || out_ch.ready) begin
            o_vld_r   <= 1'b1;
            o_pc_r    <= pc_r;
            o_ov_r    <= r_ov_r;
            o_val_r   <= r_val_r;
            o_halt_r  <= stop_r;
            o_fault_r <= r_fault_r;
            state_r   <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready      = (state_r == S_IDLE);
  assign out_ch.valid     = o_vld_r;
  assign out_ch.pc        = o_pc_r;
  assign out_ch.out_valid = o_ov_r;
  assign out_ch.out_value = o_val_r;
  assign out_ch.halted    = o_halt_r;
  assign out_ch.fault     = o_fault_r;

  a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    stop_r |=> stop_r)
    else $error("stop flag cleared without reset");

  a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
    !(rf_we && mem_we))
    else $error("register file and memory written in the same cycle");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("second transaction accepted before the first finished");

  a_load_keeps_pc: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.command == CMD_LOAD) |=> $stable(pc_r))
    else $error("load command changed the program counter");

endmodule
